// ----- design/sos_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_pkg: shared types and constants
// Controller states and the command/status bundles of the outline sweep.
// ----------------------------------------------------------------------------
package sos_pkg;

  localparam int unsigned MaxBuildingsDef = 16;
  localparam int unsigned CoordBitsDef    = 16;
  localparam int unsigned FieldBits       = 16;
  localparam int unsigned MaxOut          = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVLOAD,
    ST_SORT,
    ST_EVFETCH,
    ST_EVRUN,
    ST_TOPSCAN,
    ST_POPSCAN,
    ST_EMIT,
    ST_CLEAR
  } sos_state_e;

  typedef struct packed {
    logic store;      // write building
    logic ev_init;    // start event build
    logic ev_load;    // load one event pair
    logic sort_init;
    logic sort_step;  // one compare/swap
    logic ev_fetch;   // latch next event
    logic ev_exec;    // act on latched event
    logic scan_init;
    logic scan_step;
    logic pop_step;   // act on scan result in pop loop
    logic emit;
    logic clear;
  } sos_cmd_t;

  typedef struct packed {
    logic ev_load_done;
    logic sort_done;
    logic ev_done;
    logic out_empty;  // no outline point recorded
    logic need_pop;   // latched event ends the heap top
    logic scan_done;
    logic pop_done;
    logic emit_done;
  } sos_sts_t;

endpackage

// ----- design/sos_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_datapath: building store, event sort, heap and outline store
// Every step is one command from the controller; one element per cycle.
// ----------------------------------------------------------------------------
module sos_datapath #(
  parameter int unsigned MaxBuildings = sos_pkg::MaxBuildingsDef,
  parameter int unsigned CoordBits    = sos_pkg::CoordBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sos_pkg::sos_cmd_t          cmd_i,
  output sos_pkg::sos_sts_t          sts_o,
  input  logic [sos_pkg::FieldBits-1:0] left_edge_i,
  input  logic [sos_pkg::FieldBits-1:0] height_i,
  input  logic [sos_pkg::FieldBits-1:0] right_edge_i,
  output logic [sos_pkg::FieldBits-1:0] point_x_o,
  output logic [sos_pkg::FieldBits-1:0] point_height_o,
  output logic                       last_point_o,
  output logic                       overflow_o
);
  import sos_pkg::*;

  localparam int unsigned IdxW   = $clog2(MaxBuildings + 1);
  localparam int unsigned BW     = (MaxBuildings > 1) ? $clog2(MaxBuildings) : 1;
  localparam int unsigned NEv    = 2 * MaxBuildings;
  localparam int unsigned EW     = $clog2(NEv + 1);
  localparam int unsigned EAW    = $clog2(NEv);
  localparam int unsigned OutW   = $clog2(NEv + 1);
  localparam int unsigned OAW    = $clog2(NEv);
  localparam int unsigned CW     = (CoordBits < FieldBits) ? CoordBits : FieldBits;
  localparam int unsigned OutCap = (NEv < MaxOut) ? NEv : MaxOut;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [BW-1:0] id;
  } ev_t;

  // building store
  logic [CW-1:0]        bl_q [MaxBuildings];
  logic [CW-1:0]        br_q [MaxBuildings];
  logic [FieldBits-1:0] bh_q [MaxBuildings];
  logic [IdxW-1:0]      cnt_q;
  logic                 drop_q;

  // events
  ev_t                  ev_q [NEv];
  logic [EW-1:0]        ne_q;
  logic [IdxW-1:0]      ldi_q;
  logic [EW-1:0]        si_q, sj_q;   // insertion sort indices
  ev_t                  sv_q;         // value being inserted
  logic                 shifting_q;
  logic [EW-1:0]        ep_q;         // sweep position
  ev_t                  cur_q;

  // heap (unordered, scanned for top)
  logic [BW-1:0]        hp_q [MaxBuildings];
  logic [IdxW-1:0]      hs_q;
  logic [MaxBuildings-1:0] act_q;
  logic [IdxW-1:0]      sk_q;
  logic [BW-1:0]        best_q;       // position of top

  // outline
  logic [CW+FieldBits-1:0] os_q [NEv];
  logic [OutW-1:0]      oc_q;
  logic [OutW-1:0]      emi_q;
  logic                 have_prev_q;
  logic [CW-1:0]        lx_q;
  logic [FieldBits-1:0] lh_q, ph_q;   // last height, height before last

  // ------------------------------------------------------------------
  logic [BW-1:0] cand_id, best_id;
  logic          cand_better;
  assign cand_id  = hp_q[sk_q[BW-1:0]];
  assign best_id  = hp_q[best_q];
  assign cand_better = (bh_q[cand_id] > bh_q[best_id]) ||
                       ((bh_q[cand_id] == bh_q[best_id]) && (cand_id > best_id));

  ev_t prev_ev;
  assign prev_ev = ev_q[sj_q[EAW-1:0] - EAW'(1)];

  logic cur_active;
  assign cur_active = act_q[cur_q.id];

  // record a point: whether to write and the height to record
  logic [FieldBits-1:0] rec_h;
  logic                 rec_en;

  always_comb begin
    rec_en = 1'b0;
    rec_h  = '0;
    if (cmd_i.ev_exec) begin
      if (cur_active) begin
        // end event: id is marked inactive; if it is the heap top, the pop path records
      end else if (hs_q == '0 || bh_q[cur_q.id] > bh_q[best_id]) begin
        rec_en = 1'b1;
        rec_h  = bh_q[cur_q.id];
      end
    end else if (cmd_i.pop_step && (hs_q == '0 || act_q[best_id])) begin
      rec_en = 1'b1;
      rec_h  = (hs_q == '0) ? '0 : bh_q[best_id];
    end
  end

  always_comb begin
    sts_o.ev_load_done = (ldi_q == cnt_q);
    sts_o.sort_done    = (si_q >= ne_q) && !shifting_q;
    sts_o.ev_done      = (ep_q == ne_q);
    sts_o.out_empty    = (oc_q == '0);
    sts_o.need_pop     = cur_active && (hs_q != '0) && (best_id == cur_q.id);
    sts_o.scan_done    = (sk_q >= hs_q);
    sts_o.pop_done     = (hs_q == '0) || act_q[best_id];
    sts_o.emit_done    = (emi_q + OutW'(1) >= oc_q) ||
                         (emi_q + OutW'(1) >= OutW'(OutCap));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; drop_q <= 1'b0; ne_q <= '0; ldi_q <= '0;
      si_q <= '0; sj_q <= '0; shifting_q <= 1'b0; ep_q <= '0;
      hs_q <= '0; act_q <= '0; sk_q <= '0; best_q <= '0;
      oc_q <= '0; emi_q <= '0; have_prev_q <= 1'b0;
      lx_q <= '0; lh_q <= '0; ph_q <= '0;
    end else begin
      if (cmd_i.store) begin
        if (cnt_q < IdxW'(MaxBuildings)) cnt_q <= cnt_q + IdxW'(1);
        else drop_q <= 1'b1;
      end
      if (cmd_i.ev_init) begin
        ldi_q <= '0; ne_q <= '0;
      end
      if (cmd_i.ev_load) begin
        ldi_q <= ldi_q + IdxW'(1);
        ne_q  <= ne_q + EW'(2);
      end
      if (cmd_i.sort_init) begin
        si_q <= EW'(1); shifting_q <= 1'b0;
      end
      if (cmd_i.sort_step) begin
        if (!shifting_q) begin
          if (si_q < ne_q) begin
            sj_q <= si_q; shifting_q <= 1'b1;
          end
        end else if (sj_q != '0 && prev_ev > sv_q) begin
          sj_q <= sj_q - EW'(1);
        end else begin
          shifting_q <= 1'b0;
          si_q <= si_q + EW'(1);
        end
      end
      if (cmd_i.ev_fetch) begin
        ep_q <= ep_q + EW'(1);
      end
      if (cmd_i.scan_init) begin
        sk_q <= IdxW'(1); best_q <= '0;
      end
      if (cmd_i.scan_step && sk_q < hs_q) begin
        if (cand_better) best_q <= sk_q[BW-1:0];
        sk_q <= sk_q + IdxW'(1);
      end
      if (cmd_i.ev_exec) begin
        if (cur_active) begin
          act_q[cur_q.id] <= 1'b0;
        end else begin
          act_q[cur_q.id] <= 1'b1;
          if (hs_q < IdxW'(MaxBuildings)) hs_q <= hs_q + IdxW'(1);
        end
      end
      if (cmd_i.pop_step && !(hs_q == '0 || act_q[best_id])) begin
        hs_q <= hs_q - IdxW'(1);
      end
      if (rec_en) begin
        if (have_prev_q && lx_q == cur_q.x) begin
          // replace latest point, or drop it if the height matches the one before
          if (rec_h == ph_q) begin
            oc_q <= oc_q - OutW'(1);
            lh_q <= ph_q;
            have_prev_q <= (oc_q > OutW'(1));
            if (oc_q > OutW'(1)) begin
              lx_q <= os_q[oc_q[OAW-1:0] - OAW'(2)][CW+FieldBits-1:FieldBits];
              ph_q <= (oc_q > OutW'(2)) ?
                      os_q[oc_q[OAW-1:0] - OAW'(3)][FieldBits-1:0] : '0;
            end
          end else begin
            lh_q <= rec_h;
          end
        end else if (rec_h != (have_prev_q ? lh_q : '0)) begin
          if (oc_q < OutW'(NEv)) begin
            oc_q <= oc_q + OutW'(1);
            ph_q <= have_prev_q ? lh_q : '0;
            lh_q <= rec_h;
            lx_q <= cur_q.x;
            have_prev_q <= 1'b1;
          end
        end
      end
      if (cmd_i.emit) emi_q <= emi_q + OutW'(1);
      if (cmd_i.clear) begin
        cnt_q <= '0; drop_q <= 1'b0; hs_q <= '0; act_q <= '0;
        oc_q <= '0; emi_q <= '0; have_prev_q <= 1'b0; ep_q <= '0;
      end
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && cnt_q < IdxW'(MaxBuildings)) begin
      bl_q[cnt_q[BW-1:0]] <= left_edge_i[CW-1:0];
      br_q[cnt_q[BW-1:0]] <= right_edge_i[CW-1:0];
      bh_q[cnt_q[BW-1:0]] <= height_i;
    end
    if (cmd_i.ev_load) begin
      ev_q[ne_q[EAW-1:0]]            <= '{x: bl_q[ldi_q[BW-1:0]], id: ldi_q[BW-1:0]};
      ev_q[ne_q[EAW-1:0] + EAW'(1)]  <= '{x: br_q[ldi_q[BW-1:0]], id: ldi_q[BW-1:0]};
    end
    if (cmd_i.sort_step) begin
      if (!shifting_q) begin
        if (si_q < ne_q) sv_q <= ev_q[si_q[EAW-1:0]];
      end else if (sj_q != '0 && prev_ev > sv_q) begin
        ev_q[sj_q[EAW-1:0]] <= prev_ev;
      end else begin
        ev_q[sj_q[EAW-1:0]] <= sv_q;
      end
    end
    if (cmd_i.ev_fetch) cur_q <= ev_q[ep_q[EAW-1:0]];
    if (cmd_i.ev_exec && !cur_active && hs_q < IdxW'(MaxBuildings))
      hp_q[hs_q[BW-1:0]] <= cur_q.id;
    if (cmd_i.pop_step && !(hs_q == '0 || act_q[best_id]))
      hp_q[best_q] <= hp_q[hs_q[BW-1:0] - BW'(1)];
    if (rec_en) begin
      if (have_prev_q && lx_q == cur_q.x) begin
        if (rec_h != ph_q) os_q[oc_q[OAW-1:0] - OAW'(1)] <= {cur_q.x, rec_h};
      end else if (rec_h != (have_prev_q ? lh_q : '0) && oc_q < OutW'(NEv)) begin
        os_q[oc_q[OAW-1:0]] <= {cur_q.x, rec_h};
      end
    end
  end

  logic [CW+FieldBits-1:0] out_word;
  assign out_word       = os_q[emi_q[OAW-1:0]];
  assign point_x_o      = FieldBits'(out_word[CW+FieldBits-1:FieldBits]);
  assign point_height_o = out_word[FieldBits-1:0];
  assign last_point_o   = sts_o.emit_done;
  assign overflow_o     = drop_q;

`ifndef SYNTHESIS
  a_heap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hs_q <= IdxW'(MaxBuildings)) else $error("heap size out of range");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IdxW'(MaxBuildings)) else $error("building count out of range");
  a_out_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oc_q <= OutW'(NEv)) else $error("outline count out of range");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (hs_q == '0 && oc_q == '0 && act_q == '0))
    else $error("state not cleared");
`endif
endmodule

// ----- design/sos_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_ctrl: sequencing state machine
// Steps the datapath through load, sort, sweep and emission.
// ----------------------------------------------------------------------------
module sos_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_building_i,
  input  sos_pkg::sos_sts_t sts_i,
  output sos_pkg::sos_cmd_t cmd_o,
  output logic              busy_o,
  output logic              point_valid_o
);
  import sos_pkg::*;

  sos_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (start_i && last_building_i) state_d = ST_EVLOAD;
      ST_EVLOAD:  if (sts_i.ev_load_done) state_d = ST_SORT;
      ST_SORT:    if (sts_i.sort_done) state_d = ST_EVFETCH;
      ST_EVFETCH: begin
        if (!sts_i.ev_done)       state_d = ST_TOPSCAN;
        else if (sts_i.out_empty) state_d = ST_CLEAR;
        else                      state_d = ST_EMIT;
      end
      ST_TOPSCAN: if (sts_i.scan_done) state_d = ST_EVRUN;
      ST_EVRUN:   state_d = sts_i.need_pop ? ST_POPSCAN : ST_EVFETCH;
      ST_POPSCAN: if (sts_i.scan_done && sts_i.pop_done) state_d = ST_EVFETCH;
      ST_EMIT:    if (sts_i.emit_done) state_d = ST_CLEAR;
      ST_CLEAR:   state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = (state_q != ST_IDLE);
    point_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.store   = start_i;
        cmd_o.ev_init = start_i && last_building_i;
      end
      ST_EVLOAD: begin
        cmd_o.ev_load   = !sts_i.ev_load_done;
        cmd_o.sort_init = sts_i.ev_load_done;
      end
      ST_SORT:    cmd_o.sort_step = 1'b1;
      ST_EVFETCH: begin
        cmd_o.ev_fetch  = !sts_i.ev_done;
        cmd_o.scan_init = 1'b1;
      end
      ST_TOPSCAN: cmd_o.scan_step = 1'b1;
      ST_EVRUN:   cmd_o.ev_exec = 1'b1;
      // pop loop: once the scan settles, pop an inactive top and rescan,
      // or record the surviving top and move on
      ST_POPSCAN: begin
        cmd_o.scan_step = !sts_i.scan_done;
        cmd_o.pop_step  = sts_i.scan_done;
        cmd_o.scan_init = sts_i.scan_done && !sts_i.pop_done;
      end
      ST_EMIT: begin
        cmd_o.emit    = 1'b1;
        point_valid_o = 1'b1;
      end
      ST_CLEAR: cmd_o.clear = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o |-> busy_o) else $error("emit while idle");
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |=> state_q == ST_IDLE) else $error("clear not final");
  a_store_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store |-> !busy_o) else $error("store while busy");
`endif
endmodule

// ----- design/skyline_outline_sweep_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skyline_outline_sweep_top: building outline generator
// Loads buildings, sorts edge events, sweeps a height heap, emits points.
// ----------------------------------------------------------------------------
// Usage:
//  - Input transaction: start high while busy low loads one building
//    (left_edge_i, height_i, right_edge_i). Buildings load back to back
//    while last_building_i is low.
//  - last_building_i on a transaction runs the sweep; busy stays high
//    until the outline has been emitted and state cleared.
//  - Sweep sequence for N stored buildings: event load, insertion sort of
//    the 2N events, then per event a fetch, a linear heap scan and an
//    execute step, plus a heap rescan per heap pop; emission one point
//    per cycle, then a clear.
//  - Each point appears for one cycle with point_valid_o; last_point_o
//    marks the final point, overflow_o reports dropped buildings.
//  - The receiver cannot stall; points are never held.
//  - Reset clears counts, heap and outline; stores need no clearing.
// ----------------------------------------------------------------------------
module skyline_outline_sweep_top #(
  parameter int unsigned MaxBuildings = sos_pkg::MaxBuildingsDef,
  parameter int unsigned CoordBits    = sos_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [sos_pkg::FieldBits-1:0] left_edge_i,
  input  logic [sos_pkg::FieldBits-1:0] height_i,
  input  logic [sos_pkg::FieldBits-1:0] right_edge_i,
  input  logic                          last_building_i,
  output logic                          point_valid_o,
  output logic [sos_pkg::FieldBits-1:0] point_x_o,
  output logic [sos_pkg::FieldBits-1:0] point_height_o,
  output logic                          last_point_o,
  output logic                          overflow_o
);
  import sos_pkg::*;

  sos_cmd_t cmd;
  sos_sts_t sts;

  sos_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .last_building_i,
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy), .point_valid_o
  );

  sos_datapath #(.MaxBuildings(MaxBuildings), .CoordBits(CoordBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .left_edge_i, .height_i, .right_edge_i,
    .point_x_o, .point_height_o, .last_point_o, .overflow_o
  );

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_building_i) |=> busy) else $error("sweep not started");
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_valid_o && last_point_o) |=> !point_valid_o) else $error("point after last");
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o |-> busy) else $error("point while idle");
`endif
endmodule
